/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl of the indexed min priority queue
// depends on nothing; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* hw/rtl/impq_pkg.sv */
// types, codes and sizes of the indexed min priority queue
// depends on nothing
package impq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int ID_COUNT   = 64;
    localparam int KEY_BITS   = 32;
    localparam int PAY_BITS   = 32;
    localparam int ID_BITS    = 6;
    localparam int IDX_BITS   = 6;
    localparam int SLOT_BITS  = 7;

    typedef enum logic [2:0] {
        CMD_ENQ    = 3'd0,
        CMD_DEQ    = 3'd1,
        CMD_REWGT  = 3'd2,
        CMD_PEEK   = 3'd3,
        CMD_LOOKUP = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_PRESENT = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SET_STATUS, OP_ENQ, OP_CLEAR, OP_RD_ROOT,
        OP_DEQ_GONE, OP_DEQ_LAST, OP_DEQ_KEY, OP_RW_RD, OP_RW_SET,
        OP_LK_RD, OP_LK_SET, OP_UP_RD, OP_UP_PID, OP_UP_MOVE,
        OP_DN_RD, OP_DN_A, OP_DN_B, OP_DN_MOVE, OP_FIN_W,
        OP_HEAD_ID, OP_HEAD_KEY, OP_PUBLISH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_DEQ_GONE, S_DEQ_LAST, S_DEQ_KEY, S_RW, S_LK,
        S_UP_CHK, S_UP_PID, S_UP_CMP, S_DN_CHK, S_DN_A, S_DN_B, S_DN_C,
        S_FIN_W, S_HEAD, S_HEAD_ID, S_HEAD_KEY, S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic held;
        logic empty;
        logic full;
        logic at_root;
        logic no_child;
        logic key_less;
        logic dn_stop;
    } dp_stat_t;

endpackage

/* hw/rtl/indexed_min_priority_queue_top.sv */
// top level of the indexed min priority queue
// depends on impq_pkg, impq_ctrl, impq_dp (which holds the impq_ram instances)
//
// indexed binary min-heap of up to 64 item ids ordered by a 32-bit staleness
// key, one command beat in and one result beat out. enqueue, dequeue of the
// least key, reweight of a held id, peek, lookup and clear are supported; each
// result carries a status, the head after the command and the item count.
// commands are worked one at a time by a sequencer over four rams with one
// write port and one registered read port each (heap slots, slot of each id,
// key and payload of each id); a new command beat is taken once the
// previous result is in the output register. enqueue and reweight climb
// or sink one level at a time and dequeue sinks from the root; a sift in a
// full heap crosses at most 6 levels, and the one-read-per-cycle heap ram
// sets the cost of each level. presence of each id lives in flip-flops
// cleared by reset and by clear, so no clearing pass is needed and the
// block is ready right after reset.
module indexed_min_priority_queue_top import impq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_command,
    input  logic [ID_BITS-1:0]   s_item_id,
    input  logic [KEY_BITS-1:0]  s_key_value,
    input  logic [PAY_BITS-1:0]  s_payload_handle,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic                 m_head_valid,
    output logic [ID_BITS-1:0]   m_head_id,
    output logic [KEY_BITS-1:0]  m_head_key,
    output logic [KEY_BITS-1:0]  m_lookup_key,
    output logic [PAY_BITS-1:0]  m_lookup_payload,
    output logic [SLOT_BITS-1:0] m_item_count
);

    // command and status between sequencer and datapath
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    impq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    impq_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .dp_cmd           (dp_cmd),
        .dp_stat          (dp_stat),
        .s_command        (s_command),
        .s_item_id        (s_item_id),
        .s_key_value      (s_key_value),
        .s_payload_handle (s_payload_handle),
        .m_status         (m_status),
        .m_head_valid     (m_head_valid),
        .m_head_id        (m_head_id),
        .m_head_key       (m_head_key),
        .m_lookup_key     (m_lookup_key),
        .m_lookup_payload (m_lookup_payload),
        .m_item_count     (m_item_count)
    );

endmodule

/* hw/rtl/impq_ram.sv */
// generic single write port, single read port ram with registered read
// depends on nothing
module impq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hw/rtl/impq_dp.sv */
// datapath: heap, slot, key and payload rams, sift registers, result registers
// depends on impq_pkg, impq_ram and assert_macros.svh
`include "assert_macros.svh"
module impq_dp import impq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              dp_cmd,
    output dp_stat_t             dp_stat,
    input  logic [2:0]           s_command,
    input  logic [ID_BITS-1:0]   s_item_id,
    input  logic [KEY_BITS-1:0]  s_key_value,
    input  logic [PAY_BITS-1:0]  s_payload_handle,
    output logic [2:0]           m_status,
    output logic                 m_head_valid,
    output logic [ID_BITS-1:0]   m_head_id,
    output logic [KEY_BITS-1:0]  m_head_key,
    output logic [KEY_BITS-1:0]  m_lookup_key,
    output logic [PAY_BITS-1:0]  m_lookup_payload,
    output logic [SLOT_BITS-1:0] m_item_count
);

    cmd_t                 cmd_reg;
    status_t              status_reg;
    logic [ID_BITS-1:0]   id_reg, ida_reg, idb_reg, hid_reg;
    logic [KEY_BITS-1:0]  key_reg, ka_reg, lk_reg, hkey_reg;
    logic [PAY_BITS-1:0]  pay_reg, lp_reg;
    logic [SLOT_BITS-1:0] cnt_reg, pos_reg, child_reg;
    logic [ID_COUNT-1:0]  valid_reg;

    logic                 h_we, sl_we, k_we, p_we;
    logic [IDX_BITS-1:0]  h_waddr, h_raddr;
    logic [ID_BITS-1:0]   h_wdata, h_rdata;
    logic [ID_BITS-1:0]   sl_waddr, sl_raddr, k_waddr, k_raddr, p_waddr, p_raddr;
    logic [SLOT_BITS-1:0] sl_wdata, sl_rdata;
    logic [KEY_BITS-1:0]  k_wdata, k_rdata;
    logic [PAY_BITS-1:0]  p_wdata, p_rdata;

    logic [SLOT_BITS-1:0] pos_m1, par, par_m1, cnt_m1, right, best_pos;
    logic [SLOT_BITS:0]   left, left_m1;
    logic                 take_right;
    logic [KEY_BITS-1:0]  best_key;
    logic [ID_BITS-1:0]   best_id;

    assign pos_m1  = pos_reg - SLOT_BITS'(1);
    assign par     = {1'b0, pos_reg[SLOT_BITS-1:1]};
    assign par_m1  = par - SLOT_BITS'(1);
    assign cnt_m1  = cnt_reg - SLOT_BITS'(1);
    assign left    = {pos_reg, 1'b0};
    assign left_m1 = left - (SLOT_BITS+1)'(1);
    assign right   = child_reg + SLOT_BITS'(1);

    // right child wins only on a strictly smaller key
    assign take_right = (right <= cnt_reg) && (k_rdata < ka_reg);
    assign best_key   = take_right ? k_rdata : ka_reg;
    assign best_id    = take_right ? idb_reg : ida_reg;
    assign best_pos   = take_right ? right : child_reg;

    assign dp_stat.cmd      = cmd_reg;
    assign dp_stat.held     = valid_reg[id_reg];
    assign dp_stat.empty    = (cnt_reg == '0);
    assign dp_stat.full     = (cnt_reg == SLOT_BITS'(HEAP_DEPTH));
    assign dp_stat.at_root  = (pos_reg == SLOT_BITS'(1));
    assign dp_stat.no_child = (left > {1'b0, cnt_reg});
    assign dp_stat.key_less = (key_reg < k_rdata);
    assign dp_stat.dn_stop  = (key_reg <= best_key);

    always_comb begin
        h_we = 1'b0;  h_waddr = pos_m1[IDX_BITS-1:0];  h_wdata = id_reg;
        h_raddr = '0;
        sl_we = 1'b0; sl_waddr = id_reg; sl_wdata = pos_reg; sl_raddr = id_reg;
        k_we = 1'b0;  k_waddr = id_reg;  k_wdata = key_reg;  k_raddr = id_reg;
        p_we = 1'b0;  p_waddr = id_reg;  p_wdata = pay_reg;  p_raddr = id_reg;
        case (dp_cmd.op)
            OP_ENQ: begin
                k_we = 1'b1;
                p_we = 1'b1;
            end
            OP_DEQ_GONE: begin
                k_raddr = h_rdata;
                p_raddr = h_rdata;
                h_raddr = cnt_m1[IDX_BITS-1:0];
            end
            OP_RW_SET:   k_we = 1'b1;
            OP_UP_RD:    h_raddr = par_m1[IDX_BITS-1:0];
            OP_UP_MOVE: begin
                h_we = 1'b1;  h_wdata = ida_reg;
                sl_we = 1'b1; sl_waddr = ida_reg;
            end
            OP_DN_RD:    h_raddr = left_m1[IDX_BITS-1:0];
            OP_DN_A: begin
                k_raddr = h_rdata;
                h_raddr = child_reg[IDX_BITS-1:0];
            end
            OP_DN_MOVE: begin
                h_we = 1'b1;  h_wdata = best_id;
                sl_we = 1'b1; sl_waddr = best_id;
            end
            OP_FIN_W: begin
                h_we = 1'b1;
                sl_we = 1'b1;
            end
            OP_DEQ_LAST, OP_UP_PID, OP_DN_B: k_raddr = h_rdata;
            OP_HEAD_ID: begin
                k_raddr = h_rdata;
                p_raddr = h_rdata;
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            valid_reg <= '0;
        end else begin
            case (dp_cmd.op)
                OP_ENQ: begin
                    cnt_reg           <= cnt_reg + SLOT_BITS'(1);
                    valid_reg[id_reg] <= 1'b1;
                end
                OP_CLEAR: begin
                    cnt_reg   <= '0;
                    valid_reg <= '0;
                end
                OP_DEQ_LAST: begin
                    cnt_reg            <= cnt_m1;
                    valid_reg[ida_reg] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // command, payload, sift and result registers
    always_ff @(posedge aclk) begin
        case (dp_cmd.op)
            OP_LOAD: begin
                cmd_reg    <= cmd_t'(s_command);
                id_reg     <= s_item_id;
                key_reg    <= s_key_value;
                pay_reg    <= s_payload_handle;
                status_reg <= ST_OK;
                lk_reg     <= '0;
                lp_reg     <= '0;
                hid_reg    <= '0;
                hkey_reg   <= '0;
            end
            OP_SET_STATUS: status_reg <= dp_cmd.code;
            OP_ENQ:        pos_reg <= cnt_reg + SLOT_BITS'(1);
            OP_DEQ_GONE:   ida_reg <= h_rdata;
            OP_DEQ_LAST: begin
                lk_reg  <= k_rdata;
                lp_reg  <= p_rdata;
                id_reg  <= h_rdata;
                pos_reg <= SLOT_BITS'(1);
            end
            OP_DEQ_KEY:    key_reg <= k_rdata;
            OP_RW_SET:     pos_reg <= sl_rdata;
            OP_LK_SET: begin
                lk_reg <= k_rdata;
                lp_reg <= p_rdata;
            end
            OP_UP_PID:     ida_reg <= h_rdata;
            OP_UP_MOVE:    pos_reg <= par;
            OP_DN_RD:      child_reg <= left[SLOT_BITS-1:0];
            OP_DN_A:       ida_reg <= h_rdata;
            OP_DN_B: begin
                ka_reg  <= k_rdata;
                idb_reg <= h_rdata;
            end
            OP_DN_MOVE:    pos_reg <= best_pos;
            OP_HEAD_ID:    hid_reg <= h_rdata;
            OP_HEAD_KEY: begin
                hkey_reg <= k_rdata;
                if (cmd_reg == CMD_PEEK && status_reg == ST_OK) begin
                    lk_reg <= k_rdata;
                    lp_reg <= p_rdata;
                end
            end
            OP_PUBLISH: begin
                m_status         <= status_reg;
                m_head_valid     <= (cnt_reg != '0);
                m_head_id        <= hid_reg;
                m_head_key       <= hkey_reg;
                m_lookup_key     <= lk_reg;
                m_lookup_payload <= lp_reg;
                m_item_count     <= cnt_reg;
            end
            default: ;
        endcase
    end

    impq_ram #(.WIDTH(ID_BITS), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .aclk(aclk), .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wdata),
        .rd_addr(h_raddr), .rd_data(h_rdata)
    );

    impq_ram #(.WIDTH(SLOT_BITS), .DEPTH(ID_COUNT)) u_slot_ram (
        .aclk(aclk), .wr_en(sl_we), .wr_addr(sl_waddr), .wr_data(sl_wdata),
        .rd_addr(sl_raddr), .rd_data(sl_rdata)
    );

    impq_ram #(.WIDTH(KEY_BITS), .DEPTH(ID_COUNT)) u_key_ram (
        .aclk(aclk), .wr_en(k_we), .wr_addr(k_waddr), .wr_data(k_wdata),
        .rd_addr(k_raddr), .rd_data(k_rdata)
    );

    impq_ram #(.WIDTH(PAY_BITS), .DEPTH(ID_COUNT)) u_pay_ram (
        .aclk(aclk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
        .rd_addr(p_raddr), .rd_data(p_rdata)
    );

    // one presence bit per held item
    `ASSERT_ALWAYS(a_count_matches, aclk, aresetn, $countones(valid_reg) == cnt_reg)
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, cnt_reg <= SLOT_BITS'(HEAP_DEPTH))

endmodule

/* hw/rtl/impq_ctrl.sv */
// controller: command sequencer and result handshake
// depends on impq_pkg and assert_macros.svh
`include "assert_macros.svh"
module impq_ctrl import impq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        publish;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign publish = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_valid) state_next = S_CHECK;
            S_CHECK: begin
                state_next = S_HEAD;
                case (dp_stat.cmd)
                    CMD_ENQ:    if (!dp_stat.held && !dp_stat.full) state_next = S_UP_CHK;
                    CMD_DEQ:    if (!dp_stat.empty) state_next = S_DEQ_GONE;
                    CMD_REWGT:  if (dp_stat.held) state_next = S_RW;
                    CMD_LOOKUP: if (dp_stat.held) state_next = S_LK;
                    default: ;
                endcase
            end
            S_DEQ_GONE: state_next = S_DEQ_LAST;
            S_DEQ_LAST: state_next = S_DEQ_KEY;
            S_DEQ_KEY:  state_next = S_DN_CHK;
            S_RW:       state_next = dp_stat.key_less ? S_UP_CHK : S_DN_CHK;
            S_LK:       state_next = S_HEAD;
            S_UP_CHK:   state_next = dp_stat.at_root ? S_FIN_W : S_UP_PID;
            S_UP_PID:   state_next = S_UP_CMP;
            S_UP_CMP:   state_next = dp_stat.key_less ? S_UP_CHK : S_FIN_W;
            S_DN_CHK:   state_next = dp_stat.no_child ? S_FIN_W : S_DN_A;
            S_DN_A:     state_next = S_DN_B;
            S_DN_B:     state_next = S_DN_C;
            S_DN_C:     state_next = dp_stat.dn_stop ? S_FIN_W : S_DN_CHK;
            S_FIN_W:    state_next = S_HEAD;
            S_HEAD:     state_next = dp_stat.empty ? S_DONE : S_HEAD_ID;
            S_HEAD_ID:  state_next = S_HEAD_KEY;
            S_HEAD_KEY: state_next = S_DONE;
            S_DONE:     if (publish) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dp_cmd.op   = OP_NONE;
        dp_cmd.code = ST_OK;
        unique case (state_reg)
            S_IDLE:     if (s_valid) dp_cmd.op = OP_LOAD;
            S_CHECK: begin
                case (dp_stat.cmd)
                    CMD_ENQ: begin
                        if (dp_stat.held) begin
                            dp_cmd.op = OP_SET_STATUS; dp_cmd.code = ST_PRESENT;
                        end else if (dp_stat.full) begin
                            dp_cmd.op = OP_SET_STATUS; dp_cmd.code = ST_FULL;
                        end else begin
                            dp_cmd.op = OP_ENQ;
                        end
                    end
                    CMD_DEQ, CMD_PEEK: begin
                        if (dp_stat.empty) begin
                            dp_cmd.op = OP_SET_STATUS; dp_cmd.code = ST_EMPTY;
                        end else if (dp_stat.cmd == CMD_DEQ) begin
                            dp_cmd.op = OP_RD_ROOT;
                        end
                    end
                    CMD_REWGT, CMD_LOOKUP: begin
                        if (!dp_stat.held) begin
                            dp_cmd.op = OP_SET_STATUS; dp_cmd.code = ST_UNKNOWN;
                        end else if (dp_stat.cmd == CMD_REWGT) begin
                            dp_cmd.op = OP_RW_RD;
                        end else begin
                            dp_cmd.op = OP_LK_RD;
                        end
                    end
                    CMD_CLEAR: dp_cmd.op = OP_CLEAR;
                    default: ;
                endcase
            end
            S_DEQ_GONE: dp_cmd.op = OP_DEQ_GONE;
            S_DEQ_LAST: dp_cmd.op = OP_DEQ_LAST;
            S_DEQ_KEY:  dp_cmd.op = OP_DEQ_KEY;
            S_RW:       dp_cmd.op = OP_RW_SET;
            S_LK:       dp_cmd.op = OP_LK_SET;
            S_UP_CHK:   if (!dp_stat.at_root) dp_cmd.op = OP_UP_RD;
            S_UP_PID:   dp_cmd.op = OP_UP_PID;
            S_UP_CMP:   if (dp_stat.key_less) dp_cmd.op = OP_UP_MOVE;
            S_DN_CHK:   if (!dp_stat.no_child) dp_cmd.op = OP_DN_RD;
            S_DN_A:     dp_cmd.op = OP_DN_A;
            S_DN_B:     dp_cmd.op = OP_DN_B;
            S_DN_C:     if (!dp_stat.dn_stop) dp_cmd.op = OP_DN_MOVE;
            S_FIN_W:    dp_cmd.op = OP_FIN_W;
            S_HEAD:     if (!dp_stat.empty) dp_cmd.op = OP_RD_ROOT;
            S_HEAD_ID:  dp_cmd.op = OP_HEAD_ID;
            S_HEAD_KEY: dp_cmd.op = OP_HEAD_KEY;
            S_DONE:     if (publish) dp_cmd.op = OP_PUBLISH;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_NEXT(a_publish_shows, aclk, aresetn, publish, m_valid && s_ready)

endmodule

/* bench/tb_top.sv */
// self-checking bench for indexed_min_priority_queue_top: commands in, results checked
// against a heap model kept inside the bench; depends on impq_pkg and the rtl top
module tb_top;
    import impq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [2:0]           s_command;
    logic [ID_BITS-1:0]   s_item_id;
    logic [KEY_BITS-1:0]  s_key_value;
    logic [PAY_BITS-1:0]  s_payload_handle;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;
    logic                 m_head_valid;
    logic [ID_BITS-1:0]   m_head_id;
    logic [KEY_BITS-1:0]  m_head_key;
    logic [KEY_BITS-1:0]  m_lookup_key;
    logic [PAY_BITS-1:0]  m_lookup_payload;
    logic [SLOT_BITS-1:0] m_item_count;

    // unused command codes, driven on purpose
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    indexed_min_priority_queue_top u_dut (.*);

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one expected result beat
    typedef struct {
        logic [2:0]           status;
        logic                 head_valid;
        logic [ID_BITS-1:0]   head_id;
        logic [KEY_BITS-1:0]  head_key;
        logic [KEY_BITS-1:0]  lookup_key;
        logic [PAY_BITS-1:0]  lookup_payload;
        logic [SLOT_BITS-1:0] item_count;
    } heap_result_t;

    heap_result_t pending_results[$];

    // bench copy of the heap
    logic [ID_BITS-1:0]   slot_id[1:HEAP_DEPTH];
    logic [SLOT_BITS-1:0] id_slot[ID_COUNT];
    logic [KEY_BITS-1:0]  id_key[ID_COUNT];
    logic [PAY_BITS-1:0]  id_pay[ID_COUNT];
    int                   n_held;

    int  n_errors;
    int  n_beats_out;
    bit  idle_on;        // random gaps on both sides when set
    bit  sink_hold;      // long receiver hold-off
    int  n_sent;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    function automatic void swap_slots(int a, int b);
        logic [ID_BITS-1:0] t;
        t = slot_id[a];
        slot_id[a] = slot_id[b];
        slot_id[b] = t;
        id_slot[slot_id[a]] = SLOT_BITS'(a);
        id_slot[slot_id[b]] = SLOT_BITS'(b);
    endfunction

    function automatic void climb(int s);
        while (s > 1 && s <= n_held && id_key[slot_id[s]] < id_key[slot_id[s/2]]) begin
            swap_slots(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void sink(int s);
        int c;
        while (s >= 1 && 2 * s <= n_held) begin
            c = 2 * s;
            if (c + 1 <= n_held && id_key[slot_id[c+1]] < id_key[slot_id[c]]) c = c + 1;
            if (id_key[slot_id[s]] <= id_key[slot_id[c]]) return;
            swap_slots(s, c);
            s = c;
        end
    endfunction

    // apply one command to the bench heap and give the result it should produce
    function automatic heap_result_t apply_command(logic [2:0] cmd, logic [5:0] id,
                                                   logic [31:0] key, logic [31:0] pay);
        heap_result_t r;
        logic [ID_BITS-1:0] gone;
        logic [KEY_BITS-1:0] old;
        bit held;
        held = id_slot[id] != 0;
        r = '{default: '0};
        r.status = ST_OK;
        case (cmd)
            CMD_ENQ: begin
                if (held) r.status = ST_PRESENT;
                else if (n_held >= HEAP_DEPTH) r.status = ST_FULL;
                else begin
                    n_held++;
                    slot_id[n_held] = id;
                    id_slot[id] = SLOT_BITS'(n_held);
                    id_key[id] = key;
                    id_pay[id] = pay;
                    climb(n_held);
                end
            end
            CMD_DEQ: begin
                if (n_held == 0) r.status = ST_EMPTY;
                else begin
                    gone = slot_id[1];
                    r.lookup_key = id_key[gone];
                    r.lookup_payload = id_pay[gone];
                    slot_id[1] = slot_id[n_held];
                    id_slot[slot_id[1]] = SLOT_BITS'(1);
                    id_slot[gone] = '0;
                    n_held--;
                    sink(1);
                end
            end
            CMD_REWGT: begin
                if (!held) r.status = ST_UNKNOWN;
                else begin
                    old = id_key[id];
                    id_key[id] = key;
                    if (key < old) climb(id_slot[id]);
                    else sink(id_slot[id]);
                end
            end
            CMD_PEEK: begin
                if (n_held == 0) r.status = ST_EMPTY;
                else begin
                    r.lookup_key = id_key[slot_id[1]];
                    r.lookup_payload = id_pay[slot_id[1]];
                end
            end
            CMD_LOOKUP: begin
                if (!held) r.status = ST_UNKNOWN;
                else begin
                    r.lookup_key = id_key[id];
                    r.lookup_payload = id_pay[id];
                end
            end
            CMD_CLEAR: begin
                n_held = 0;
                foreach (id_slot[i]) id_slot[i] = '0;
            end
            default: ;
        endcase
        r.head_valid = n_held > 0;
        if (n_held > 0) begin
            r.head_id = slot_id[1];
            r.head_key = id_key[slot_id[1]];
        end
        r.item_count = SLOT_BITS'(n_held);
        return r;
    endfunction

    // send one command beat, optionally after a random gap
    // valid stays up after the beat; the next call or the caller drops it
    task automatic send_command(input logic [2:0] cmd, input logic [5:0] id,
                                input logic [31:0] key, input logic [31:0] pay);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_command        <= cmd;
        s_item_id        <= id;
        s_key_value      <= key;
        s_payload_handle <= pay;
        do @(posedge aclk); while (!s_ready);
        // beat taken at this edge, so predict now
        pending_results.push_back(apply_command(cmd, id, key, pay));
        n_sent++;
    endtask

    // receiver: random stall bursts, plus the long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn || sink_hold) m_ready <= 1'b0;
        else if (idle_on && $urandom_range(0, 4) == 0) m_ready <= 1'b0;
        else m_ready <= 1'b1;
    end

    // result checker: compare each accepted beat with the oldest expectation
    always @(posedge aclk) begin
        heap_result_t w;
        if (aresetn && m_valid && m_ready) begin
            n_beats_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 0, 0);
            end else begin
                w = pending_results.pop_front();
                if (m_status !== w.status) report_mismatch("status", m_status, w.status);
                if (m_head_valid !== w.head_valid)
                    report_mismatch("head_valid", m_head_valid, w.head_valid);
                if (m_head_id !== w.head_id) report_mismatch("head_id", m_head_id, w.head_id);
                if (m_head_key !== w.head_key)
                    report_mismatch("head_key", m_head_key, w.head_key);
                if (m_lookup_key !== w.lookup_key)
                    report_mismatch("lookup_key", m_lookup_key, w.lookup_key);
                if (m_lookup_payload !== w.lookup_payload)
                    report_mismatch("lookup_payload", m_lookup_payload, w.lookup_payload);
                if (m_item_count !== w.item_count)
                    report_mismatch("item_count", m_item_count, w.item_count);
            end
        end
    end

    // random key with frequent collisions and extremes
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // directed: extremes, every command and every failing case except a full heap
    task automatic test_directed();
        send_command(CMD_DEQ, 6'd0, '0, '0);                   // dequeue when empty
        send_command(CMD_PEEK, 6'd0, '0, '0);                  // peek when empty
        send_command(CMD_LOOKUP, 6'd5, '0, '0);                // lookup absent
        send_command(CMD_REWGT, 6'd5, 32'd1, '0);              // reweight absent
        send_command(CMD_ENQ, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_ENQ, 6'd0, 32'h0, 32'h0);
        send_command(CMD_ENQ, 6'd0, 32'h5, 32'h1);             // id already present
        send_command(CMD_ENQ, 6'd21, 32'hAAAA_AAAA, 32'h5555_5555);
        send_command(CMD_ENQ, 6'd42, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(CMD_PEEK, 6'd0, '0, '0);
        send_command(CMD_LOOKUP, 6'd63, '0, '0);
        send_command(CMD_REWGT, 6'd63, 32'h0, '0);             // key falls, climbs
        send_command(CMD_REWGT, 6'd63, 32'h0, '0);             // same key stays put
        send_command(CMD_REWGT, 6'd63, 32'hFFFF_FFFF, '0);     // key rises, sinks
        send_command(CMD_SPARE6, 6'd1, '0, '0);
        send_command(CMD_SPARE7, 6'd2, '0, '0);
        send_command(CMD_DEQ, 6'd0, '0, '0);
        send_command(CMD_DEQ, 6'd0, '0, '0);
        send_command(CMD_CLEAR, 6'd0, '0, '0);
        send_command(CMD_LOOKUP, 6'd42, '0, '0);                // absent after clear
    endtask

    // fill to capacity, enqueue a held id while full, then drain in key order
    task automatic test_full_heap();
        for (int i = 0; i < ID_COUNT; i++)
            send_command(CMD_ENQ, 6'(i), pick_key(), $urandom);
        send_command(CMD_ENQ, 6'(ID_COUNT - 1), 32'd3, 32'd3); // present wins over full
        for (int i = 0; i < HEAP_DEPTH + 2; i++)
            send_command(CMD_DEQ, 6'd0, '0, '0);
    endtask

    // receiver holds off while commands keep coming
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                for (int i = 0; i < 12; i++)
                    send_command(CMD_ENQ, 6'($urandom_range(0, 63)), pick_key(), $urandom);
                s_valid <= 1'b0;
            end
            begin
                repeat (300) @(posedge aclk);
                sink_hold = 1'b0;
            end
        join
    endtask

    // random mix, mostly enqueue/reweight/dequeue with a live population
    task automatic test_random(input int count);
        int c;
        logic [2:0] cmd;
        for (int i = 0; i < count; i++) begin
            c = $urandom_range(0, 99);
            if (c < 35) cmd = CMD_ENQ;
            else if (c < 55) cmd = CMD_DEQ;
            else if (c < 75) cmd = CMD_REWGT;
            else if (c < 84) cmd = CMD_PEEK;
            else if (c < 95) cmd = CMD_LOOKUP;
            else if (c < 97) cmd = CMD_CLEAR;
            else cmd = 3'($urandom_range(6, 7));
            send_command(cmd, 6'($urandom_range(0, 63)), pick_key(), $urandom);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = '0;
        s_item_id = '0;
        s_key_value = '0;
        s_payload_handle = '0;
        m_ready = 1'b0;
        n_errors = 0;
        n_beats_out = 0;
        n_sent = 0;
        n_held = 0;
        idle_on = 1'b1;
        sink_hold = 1'b0;
        foreach (id_slot[i]) id_slot[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_heap();
        test_backpressure();
        test_random(1200);
        // last stretch with no idling
        idle_on = 1'b0;
        test_random(550);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("sent %0d commands, checked %0d results incl. full heap and long stall",
                 n_sent, n_beats_out);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, far above the slowest correct run
    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
